// File: src/ddo_pkg.sv
// Package for differential drive odometry: constants, CORDIC angle table,
// state machine encoding. No dependencies.
`default_nettype none
package ddo_pkg;
  localparam int unsigned CordicIterDefault = 24;
  localparam logic [45:0] TwoPiQ48 = 46'd44798133900177;
  localparam logic [33:0] AngVelK = 34'd10430378350;
  localparam logic [29:0] GainQ30 = 30'd652032875;
  localparam logic [18:0] LinVelK = 19'd500000;
  localparam logic [15:0] AxleReset = 16'd2560;

  localparam logic [1:0] RegAxle = 2'd0;
  localparam logic [1:0] RegX = 2'd1;
  localparam logic [1:0] RegY = 2'd2;
  localparam logic [1:0] RegHead = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIVH  = 8'b0000_0010,
    S_DIVT  = 8'b0000_0100,
    S_ROT   = 8'b0000_1000,
    S_GAIN  = 8'b0001_0000,
    S_DIVL  = 8'b0010_0000,
    S_DIVA  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: src/ddo_div.sv
// Shared restoring divider, one quotient bit per cycle, truncating.
// Unsigned 64-bit numerator magnitude over 40-bit divisor. Uses ddo_pkg.
`default_nettype none
module ddo_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [39:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  import ddo_pkg::*;
  logic [63:0] n;
  logic [40:0] rem;
  logic [39:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [40:0] trial;

  assign trial = {rem[39:0], n[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        // numerator pre-biased by d/2 outside
        n    <= num;
        d    <= den;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          n   <= {n[62:0], 1'b1};
        end else begin
          rem <= trial;
          n   <= {n[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = n;
endmodule
`default_nettype wire

// File: src/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, shared adders.
// Uses ddo_pkg atan table.
`default_nettype none
module ddo_cordic #(
  parameter int unsigned CORDIC_ITERATIONS = ddo_pkg::CordicIterDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [17:0] sum,
  input  wire logic [31:0] angle,
  output logic             done,
  output logic [35:0]      cx,
  output logic [35:0]      cy
);
  import ddo_pkg::*;
  localparam int unsigned Iw = $clog2(CORDIC_ITERATIONS + 1);
  logic signed [35:0] x, y, xs, ys;
  logic signed [32:0] z;
  logic [Iw-1:0] i;
  logic busy;
  logic [31:0] a2;
  logic flip;
  logic [4:0] ti;

  assign flip = (angle + 32'h40000000) >= 32'h80000000;
  assign a2 = flip ? angle - 32'h80000000 : angle;
  assign ti = 5'(i);
  assign xs = x >>> ti;
  assign ys = y >>> ti;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i <= '0;
        x <= flip ? -({{4{sum[17]}}, sum, 14'd0}) : {{4{sum[17]}}, sum, 14'd0};
        y <= '0;
        z <= {a2[31], a2};
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed({1'b0, atan_lookup(ti)});
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed({1'b0, atan_lookup(ti)});
        end
        i <= i + 1'b1;
        if (i == Iw'(CORDIC_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign cx = x;
  assign cy = y;
endmodule
`default_nettype wire

// File: src/differential_drive_odometry.sv
// Differential drive odometry top level: registers, sequencer, output.
// Depends on ddo_pkg, ddo_div, ddo_cordic.
//
// Usage: write registers on cfg_valid/cfg_ready (index 0 axle track,
// 1..3 load x, y, heading) while idle. Each request on in_valid/in_ready
// carries wheel deltas and elapsed time; one result follows on
// out_valid/out_ready with pose, total distance and both velocities.
// out_valid rises after four passes of the single bit-serial divider
// (dtheta, half angle, linear and angular velocity), one CORDIC
// micro-rotation per cycle between the half angle and linear velocity
// passes, and the S_GAIN and S_OUT states. in_ready is low from
// acceptance until the result is taken, so a new request is not accepted
// before the last result is taken. The result register holds while the
// receiver stalls. Reset clears pose and distance, axle track to 2560.
`default_nettype none
module differential_drive_odometry #(
  parameter int unsigned CORDIC_ITERATIONS = ddo_pkg::CordicIterDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] left_delta,
  input  wire logic signed [15:0] right_delta,
  input  wire logic [15:0]        elapsed_us,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [31:0]             heading,
  output logic signed [47:0]      distance_total,
  output logic signed [31:0]      linear_velocity,
  output logic signed [31:0]      angular_velocity
);
  import ddo_pkg::*;
  state_t state;
  logic [15:0] axle;
  logic [31:0] x_acc, y_acc, h_acc;
  logic [47:0] travel;
  logic half_bit;
  logic signed [16:0] s, d;
  logic [15:0] trk, dt;
  logic [31:0] dth, half;
  logic div_start, div_done, cor_start, cor_done;
  logic [63:0] div_num, div_quo;
  logic [39:0] div_den;
  logic [35:0] cx, cy;
  logic signed [66:0] px, py;
  logic [16:0] dmag;
  logic [16:0] smag;
  logic [31:0] trkdt;
  logic [63:0] mag;
  logic neg;
  logic [31:0] qs;

  assign dmag = d[16] ? 17'(-d) : 17'(d);
  assign smag = s[16] ? 17'(-s) : 17'(s);
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_ready = (state == S_IDLE) && !out_valid && !cfg_valid;

  // divider operand selection per sequence step
  always_comb begin
    neg = d[16];
    mag = 64'(dmag) * 64'(TwoPiQ48);
    div_den = 40'(trk) << 16;
    unique case (state)
      S_DIVH: begin
        div_den = 40'(trk) << 16;
        div_num = mag + (64'(trk) << 15);
      end
      S_DIVT: begin
        div_den = 40'(trk) << 17;
        div_num = mag + (64'(trk) << 16);
      end
      S_DIVL: begin
        neg = s[16];
        div_den = 40'(dt);
        div_num = 64'(smag) * 64'(LinVelK) + 64'(dt >> 1);
      end
      S_DIVA: begin
        div_den = 40'(trkdt);
        div_num = 64'(dmag) * 64'(AngVelK) + 64'(trkdt >> 1);
      end
      default: div_num = '0;
    endcase
  end

  ddo_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  ddo_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .sum(18'(s)),
    .angle(h_acc + half), .done(cor_done), .cx(cx), .cy(cy)
  );

  assign qs = neg ? 32'(-div_quo[31:0]) : div_quo[31:0];

  function automatic logic [31:0] sat(input logic neg_in, input logic [63:0] q);
    logic [31:0] r;
    if (!neg_in) r = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    else r = (q > 64'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
    return r;
  endfunction

  function automatic logic [31:0] rnd45(input logic signed [66:0] p);
    logic [66:0] m;
    logic [21:0] q;
    m = p[66] ? 67'(-p) : 67'(p);
    q = 22'((m + (67'd1 << 44)) >> 45);
    return p[66] ? 32'(-{10'd0, q}) : {10'd0, q};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      axle <= AxleReset;
      x_acc <= '0; y_acc <= '0; h_acc <= '0; travel <= '0; half_bit <= 1'b0;
      div_start <= 1'b0; cor_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      cor_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegAxle: axle <= cfg_data[15:0];
          RegX:    x_acc <= cfg_data;
          RegY:    y_acc <= cfg_data;
          RegHead: h_acc <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          s <= 17'(left_delta) + 17'(right_delta);
          d <= 17'(right_delta) - 17'(left_delta);
          trk <= (axle == 16'd0) ? 16'd1 : axle;
          dt <= (elapsed_us == 16'd0) ? 16'd1 : elapsed_us;
          div_start <= 1'b1;
          state <= S_DIVH;
        end
        S_DIVH: begin
          trkdt <= 32'(trk) * 32'(dt);
          if (div_done) begin
            dth <= qs; div_start <= 1'b1; state <= S_DIVT;
          end
        end
        S_DIVT: if (div_done) begin
          half <= qs; cor_start <= 1'b1; state <= S_ROT;
        end
        S_ROT: if (cor_done) state <= S_GAIN;
        S_GAIN: begin
          px <= 67'(signed'(cx)) * 67'(signed'({1'b0, GainQ30}));
          py <= 67'(signed'(cy)) * 67'(signed'({1'b0, GainQ30}));
          div_start <= 1'b1;
          state <= S_DIVL;
        end
        S_DIVL: if (div_done) begin
          linear_velocity <= sat(neg, div_quo);
          div_start <= 1'b1; state <= S_DIVA;
        end
        S_DIVA: if (div_done) begin
          angular_velocity <= sat(neg, div_quo);
          state <= S_OUT;
        end
        S_OUT: begin
          x_acc <= x_acc + rnd45(px);
          y_acc <= y_acc + rnd45(py);
          h_acc <= h_acc + dth;
          travel <= travel + 48'(($signed(18'(s)) + $signed({17'd0, half_bit})) >>> 1);
          half_bit <= s[0] ^ half_bit;
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_x = x_acc;
  assign pos_y = y_acc;
  assign heading = h_acc;
  assign distance_total = travel;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("stray result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(pos_x) && $stable(heading))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
